// File: design/vpidff_pkg.sv
// ----------------------------------------------------------------------------
// Velocity PID with feedforward: shared package
// Types, constants and the microcode program of the velocity loop sequencer.
// ----------------------------------------------------------------------------
package vpidff_pkg;

   // Field and register widths
   localparam int CmdW     = 16;
   localparam int MeasW    = 18;
   localparam int VoltsW   = 16;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   // Internal datapath widths
   localparam int ErrW     = 20;
   localparam int DiffW    = 21;
   localparam int IntegW   = 40;
   localparam int DerivW   = 45;
   localparam int MagW     = 45;
   localparam int OpW      = 33;
   localparam int ProdW    = 66;
   localparam int LoW      = 64;
   localparam int FullW    = 77;
   localparam int TermW    = 51;
   localparam int AccW     = 54;
   localparam int TermIdxW = 2;

   // Gain term selection and the scaling shift of each term
   localparam logic [TermIdxW-1:0] TermP = 2'd0;
   localparam logic [TermIdxW-1:0] TermI = 2'd1;
   localparam logic [TermIdxW-1:0] TermD = 2'd2;
   localparam int ShiftP = 6;
   localparam int ShiftI = 22;
   localparam int ShiftD = 14;

   // Quiet derivative threshold (40 in Q.8) and the large error threshold
   localparam int QuietDeriv = 40 * 256;
   localparam int LargeError = 100;

   // Register indexes on the configuration port
   localparam logic [CsrAddrW-1:0] RegGainP     = 3'd0;
   localparam logic [CsrAddrW-1:0] RegGainI     = 3'd1;
   localparam logic [CsrAddrW-1:0] RegGainD     = 3'd2;
   localparam logic [CsrAddrW-1:0] RegStepTime  = 3'd3;
   localparam logic [CsrAddrW-1:0] RegStepRate  = 3'd4;
   localparam logic [CsrAddrW-1:0] RegVelScale  = 3'd5;
   localparam logic [CsrAddrW-1:0] RegMaxOutput = 3'd6;

   // Register reset values
   localparam logic [15:0] ResetStepTime  = 16'd1311;
   localparam logic [23:0] ResetStepRate  = 24'd12800;
   localparam logic [17:0] ResetVelScale  = 18'd21777;
   localparam logic [14:0] ResetMaxOutput = 15'd12288;

   typedef struct packed {
      logic [31:0] gain_p;
      logic [31:0] gain_i;
      logic [31:0] gain_d;
      logic [15:0] step_time;
      logic [23:0] step_rate;
      logic [17:0] velocity_scale;
      logic [14:0] max_output;
   } cfg_type;

   // Program steps
   localparam int StepW = 4;
   localparam logic [StepW-1:0] StepTake     = 4'd0;
   localparam logic [StepW-1:0] StepTarget   = 4'd1;
   localparam logic [StepW-1:0] StepError    = 4'd2;
   localparam logic [StepW-1:0] StepFeed     = 4'd3;
   localparam logic [StepW-1:0] StepInteg    = 4'd4;
   localparam logic [StepW-1:0] StepDerivMul = 4'd5;
   localparam logic [StepW-1:0] StepDeriv    = 4'd6;
   localparam logic [StepW-1:0] StepLoad     = 4'd7;
   localparam logic [StepW-1:0] StepMulLo    = 4'd8;
   localparam logic [StepW-1:0] StepMulHi    = 4'd9;
   localparam logic [StepW-1:0] StepTerm     = 4'd10;
   localparam logic [StepW-1:0] StepAcc      = 4'd11;
   localparam logic [StepW-1:0] StepOut      = 4'd12;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_CMD_SCALE,
      MUL_LIM_CMD,
      MUL_ERR_STEP,
      MUL_DIFF_RATE,
      MUL_MAG_LO,
      MUL_MAG_HI
   } mul_sel_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_TAKE,
      DP_ERR,
      DP_FF,
      DP_INTEG,
      DP_DERIV,
      DP_LOAD,
      DP_SAVE_LO,
      DP_TERM,
      DP_ACC,
      DP_OUT
   } dp_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_IN_WAIT,
      JMP_LOOP,
      JMP_OUT_WAIT
   } jump_type;

   typedef struct packed {
      mul_sel_type      mul;
      dp_op_type        op;
      jump_type         jmp;
      logic [StepW-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
      logic more_terms;
   } status_type;

   function automatic ctrl_type cw(input mul_sel_type mul, input dp_op_type op,
                                   input jump_type jmp, input logic [StepW-1:0] target);
      ctrl_type c;
      c.mul    = mul;
      c.op     = op;
      c.jmp    = jmp;
      c.target = target;
      return c;
   endfunction

   // The program. A multiply issued in a step lands in the product register at
   // the end of that step, so the operation of the next step sees it while the
   // multiplier may already be working on the following product.
   function automatic ctrl_type ucode(input logic [StepW-1:0] step);
      ctrl_type c;
      case (step)
         StepTake:     c = cw(MUL_NONE,      DP_TAKE,    JMP_IN_WAIT,  StepTake);
         StepTarget:   c = cw(MUL_CMD_SCALE, DP_NOP,     JMP_NEXT,     StepTake);
         StepError:    c = cw(MUL_LIM_CMD,   DP_ERR,     JMP_NEXT,     StepTake);
         StepFeed:     c = cw(MUL_ERR_STEP,  DP_FF,      JMP_NEXT,     StepTake);
         StepInteg:    c = cw(MUL_NONE,      DP_INTEG,   JMP_NEXT,     StepTake);
         StepDerivMul: c = cw(MUL_DIFF_RATE, DP_NOP,     JMP_NEXT,     StepTake);
         StepDeriv:    c = cw(MUL_NONE,      DP_DERIV,   JMP_NEXT,     StepTake);
         StepLoad:     c = cw(MUL_NONE,      DP_LOAD,    JMP_NEXT,     StepTake);
         StepMulLo:    c = cw(MUL_MAG_LO,    DP_NOP,     JMP_NEXT,     StepTake);
         StepMulHi:    c = cw(MUL_MAG_HI,    DP_SAVE_LO, JMP_NEXT,     StepTake);
         StepTerm:     c = cw(MUL_NONE,      DP_TERM,    JMP_NEXT,     StepTake);
         StepAcc:      c = cw(MUL_NONE,      DP_ACC,     JMP_LOOP,     StepLoad);
         StepOut:      c = cw(MUL_NONE,      DP_OUT,     JMP_OUT_WAIT, StepTake);
         default:      c = cw(MUL_NONE,      DP_NOP,     JMP_GOTO,     StepTake);
      endcase
      return c;
   endfunction

endpackage

// File: design/vpidff_seq.sv
// ----------------------------------------------------------------------------
// Velocity PID sequencer
// Step counter over the microcode program, with waits on the two channels
// and the loop over the three gain terms.
// ----------------------------------------------------------------------------
module vpidff_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  vpidff_pkg::status_type status,
   output vpidff_pkg::ctrl_type   ctrl
);

   logic [vpidff_pkg::StepW-1:0] step_ff;
   logic [vpidff_pkg::StepW-1:0] step_in;

   assign ctrl = vpidff_pkg::ucode(step_ff);

   always_comb begin
      unique case (ctrl.jmp)
         vpidff_pkg::JMP_NEXT: begin
            step_in = step_ff + vpidff_pkg::StepW'(1);
         end
         vpidff_pkg::JMP_GOTO: begin
            step_in = ctrl.target;
         end
         vpidff_pkg::JMP_IN_WAIT: begin
            step_in = status.in_valid ? step_ff + vpidff_pkg::StepW'(1) : step_ff;
         end
         vpidff_pkg::JMP_LOOP: begin
            step_in = status.more_terms ? ctrl.target : step_ff + vpidff_pkg::StepW'(1);
         end
         vpidff_pkg::JMP_OUT_WAIT: begin
            step_in = status.out_free ? ctrl.target : step_ff;
         end
         default: begin
            step_in = vpidff_pkg::StepTake;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= vpidff_pkg::StepTake;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: design/vpidff_dp.sv
// ----------------------------------------------------------------------------
// Velocity PID datapath
// One shared 33 by 33 bit signed multiplier, the loop state, the term
// accumulator and the result register, all steered by the control word.
// ----------------------------------------------------------------------------
module vpidff_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  vpidff_pkg::ctrl_type          ctrl,
   input  vpidff_pkg::cfg_type           cfg,
   input  logic                          req_tvalid,
   input  logic [vpidff_pkg::CmdW-1:0]   req_cmd,
   input  logic [vpidff_pkg::MeasW-1:0]  req_meas,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [vpidff_pkg::VoltsW-1:0] rsp_volts,
   output logic                          rsp_clamped,
   output vpidff_pkg::status_type        status
);

   localparam logic signed [vpidff_pkg::DerivW-1:0] QuietHi =
      vpidff_pkg::DerivW'(vpidff_pkg::QuietDeriv);
   localparam logic signed [vpidff_pkg::DerivW-1:0] QuietLo = -QuietHi;
   localparam logic signed [vpidff_pkg::ErrW-1:0] LargeErr =
      vpidff_pkg::ErrW'(vpidff_pkg::LargeError);
   localparam logic [vpidff_pkg::TermW-1:0] TermLimit = {1'b1, 50'b0};
   localparam logic signed [vpidff_pkg::IntegW-1:0] IntegMax = {1'b0, {39{1'b1}}};
   localparam logic signed [vpidff_pkg::IntegW-1:0] IntegMin = {1'b1, 39'b0};

   // Control and loop state
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [vpidff_pkg::IntegW-1:0] integ_ff, integ_in;
   logic signed [vpidff_pkg::ErrW-1:0]   prev_ff, prev_in;
   logic [vpidff_pkg::TermIdxW-1:0]      tix_ff, tix_in;

   // Working registers
   logic signed [vpidff_pkg::CmdW-1:0]   cmd_ff, cmd_in;
   logic signed [vpidff_pkg::MeasW-1:0]  meas_ff, meas_in;
   logic signed [vpidff_pkg::ProdW-1:0]  prod_ff, prod_in;
   logic signed [vpidff_pkg::ErrW-1:0]   err_ff, err_in;
   logic signed [vpidff_pkg::DiffW-1:0]  diff_ff, diff_in;
   logic signed [vpidff_pkg::DerivW-1:0] deriv_ff, deriv_in;
   logic [vpidff_pkg::MagW-1:0]          mag_ff, mag_in;
   logic                                 neg_ff, neg_in;
   logic [vpidff_pkg::LoW-1:0]           plo_ff, plo_in;
   logic [vpidff_pkg::TermW-1:0]         term_ff, term_in;
   logic signed [vpidff_pkg::AccW-1:0]   acc_ff, acc_in;
   logic [vpidff_pkg::VoltsW-1:0]        volts_ff, volts_in;
   logic                                 clamp_ff, clamp_in;

   // Combinational helpers
   logic signed [vpidff_pkg::OpW-1:0]    mul_a, mul_b;
   logic [31:0]                          gain_sel;
   logic signed [vpidff_pkg::MeasW:0]    target;
   logic signed [vpidff_pkg::IntegW:0]   isum;
   logic signed [vpidff_pkg::IntegW-1:0] integ_sat;
   logic signed [vpidff_pkg::DerivW-1:0] deriv_new;
   logic signed [vpidff_pkg::DerivW-1:0] src;
   logic [vpidff_pkg::FullW-1:0]         full;
   logic [vpidff_pkg::FullW-1:0]         shifted;
   logic [vpidff_pkg::AccW-1:0]          sterm;
   logic signed [vpidff_pkg::AccW-1:0]   lim;
   logic                                 out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign status.in_valid   = req_tvalid;
   assign status.out_free   = out_free;
   assign status.more_terms = (tix_ff != vpidff_pkg::TermD);

   always_comb begin
      case (tix_ff)
         vpidff_pkg::TermP: gain_sel = cfg.gain_p;
         vpidff_pkg::TermI: gain_sel = cfg.gain_i;
         default:           gain_sel = cfg.gain_d;
      endcase
   end

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul)
         vpidff_pkg::MUL_CMD_SCALE: begin
            mul_a = {{17{cmd_ff[15]}}, cmd_ff};
            mul_b = {15'b0, cfg.velocity_scale};
         end
         vpidff_pkg::MUL_LIM_CMD: begin
            mul_a = {18'b0, cfg.max_output};
            mul_b = {{17{cmd_ff[15]}}, cmd_ff};
         end
         vpidff_pkg::MUL_ERR_STEP: begin
            mul_a = {{13{err_ff[19]}}, err_ff};
            mul_b = {17'b0, cfg.step_time};
         end
         vpidff_pkg::MUL_DIFF_RATE: begin
            mul_a = {{12{diff_ff[20]}}, diff_ff};
            mul_b = {9'b0, cfg.step_rate};
         end
         vpidff_pkg::MUL_MAG_LO: begin
            mul_a = {1'b0, mag_ff[31:0]};
            mul_b = {1'b0, gain_sel};
         end
         vpidff_pkg::MUL_MAG_HI: begin
            mul_a = {20'b0, mag_ff[44:32]};
            mul_b = {1'b0, gain_sel};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = (ctrl.mul == vpidff_pkg::MUL_NONE) ? prod_ff : mul_a * mul_b;
   end

   // Helpers shared by the operations below
   always_comb begin
      target    = prod_ff[33:15];
      isum      = {integ_ff[39], integ_ff} + {{5{prod_ff[35]}}, prod_ff[35:0]};
      integ_sat = (isum[40] != isum[39]) ? (isum[40] ? IntegMin : IntegMax)
                                          : isum[39:0];
      deriv_new = prod_ff[44:0];
      case (tix_ff)
         vpidff_pkg::TermP: src = {{25{err_ff[19]}}, err_ff};
         vpidff_pkg::TermI: src = {{5{integ_ff[39]}}, integ_ff};
         default:           src = deriv_ff;
      endcase
      // The high partial product weighs 2^32 against the saved low one.
      full = {prod_ff[44:0], 32'b0} + {13'b0, plo_ff};
      case (tix_ff)
         vpidff_pkg::TermP: shifted = full >> vpidff_pkg::ShiftP;
         vpidff_pkg::TermI: shifted = full >> vpidff_pkg::ShiftI;
         default:           shifted = full >> vpidff_pkg::ShiftD;
      endcase
      sterm = {3'b0, term_ff};
      lim   = {39'b0, cfg.max_output};
   end

   always_comb begin
      cmd_in       = cmd_ff;
      meas_in      = meas_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      plo_in       = plo_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      tix_in       = tix_ff;
      volts_in     = volts_ff;
      clamp_in     = clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (ctrl.op)
         vpidff_pkg::DP_TAKE: begin
            if (req_tvalid) begin
               cmd_in  = req_cmd;
               meas_in = req_meas;
            end
         end
         vpidff_pkg::DP_ERR: begin
            err_in = {target[18], target} - {{2{meas_ff[17]}}, meas_ff};
         end
         vpidff_pkg::DP_FF: begin
            acc_in = {{37{prod_ff[31]}}, prod_ff[31:15]};
            tix_in = vpidff_pkg::TermP;
         end
         vpidff_pkg::DP_INTEG: begin
            integ_in = integ_sat;
            diff_in  = {err_ff[19], err_ff} - {prev_ff[19], prev_ff};
            prev_in  = err_ff;
         end
         vpidff_pkg::DP_DERIV: begin
            // A quiet derivative under a large positive error clears both D and I.
            if (deriv_new < QuietHi && deriv_new > QuietLo && err_ff > LargeErr) begin
               deriv_in = '0;
               integ_in = '0;
            end else begin
               deriv_in = deriv_new;
            end
         end
         vpidff_pkg::DP_LOAD: begin
            neg_in = src[44];
            mag_in = src[44] ? -src : src;
         end
         vpidff_pkg::DP_SAVE_LO: begin
            plo_in = prod_ff[63:0];
         end
         vpidff_pkg::DP_TERM: begin
            if (shifted > {26'b0, TermLimit}) begin
               term_in = TermLimit;
            end else begin
               term_in = shifted[50:0];
            end
         end
         vpidff_pkg::DP_ACC: begin
            acc_in = neg_ff ? acc_ff - sterm : acc_ff + sterm;
            tix_in = tix_ff + vpidff_pkg::TermIdxW'(1);
         end
         vpidff_pkg::DP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (acc_ff >= lim) begin
                  volts_in = lim[15:0];
                  clamp_in = 1'b1;
               end else if (acc_ff <= -lim) begin
                  volts_in = -lim[15:0];
                  clamp_in = 1'b1;
               end else begin
                  volts_in = acc_ff[15:0];
                  clamp_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         tix_ff       <= vpidff_pkg::TermP;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         tix_ff       <= tix_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      meas_ff  <= meas_in;
      prod_ff  <= prod_in;
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      deriv_ff <= deriv_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      plo_ff   <= plo_in;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
      volts_ff <= volts_in;
      clamp_ff <= clamp_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_volts   = volts_ff;
   assign rsp_clamped = clamp_ff;

endmodule

// File: design/velocity_pid_with_feedforward_core.sv
// ----------------------------------------------------------------------------
// Velocity PID controller with voltage feedforward
// Turns a speed command and a measured wheel velocity into a clamped drive
// voltage, keeping a saturating integral and the previous error between items.
// ----------------------------------------------------------------------------
// One item is worked at a time: the next item is taken only after the current
// one has been written to the result register. A 13-step microcode program,
// whose first step waits for the item, drives a single shared 33 by 33 bit
// multiplier, and the proportional, integral and derivative terms each take
// a five-step pass through it (load of the magnitude, two partial products,
// scaling and saturation, accumulation).
// req_tready is high only while the program waits on its first step; a
// finished result waits in its own register, so the next item is taken while
// it is still unread, and the program stalls on its last step only when a
// second result is ready before the first has been taken. Register writes
// take effect at once and are meant for times when no item is in progress.
module velocity_pid_with_feedforward_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [39:0]                      req_tdata,  // drive_command, measured_velocity
   // Result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // drive_volts
   output logic                             rsp_tuser,  // clamped
   // Configuration writes
   input  logic                             csr_we,
   input  logic [vpidff_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [vpidff_pkg::CsrDataW-1:0]  csr_wdata
);

   vpidff_pkg::cfg_type    cfg_ff;
   vpidff_pkg::cfg_type    cfg_in;
   vpidff_pkg::ctrl_type   ctrl;
   vpidff_pkg::status_type status;
   logic signed [16:0]     lim_w;
   logic signed [16:0]     volts_w;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            vpidff_pkg::RegGainP:     cfg_in.gain_p         = csr_wdata;
            vpidff_pkg::RegGainI:     cfg_in.gain_i         = csr_wdata;
            vpidff_pkg::RegGainD:     cfg_in.gain_d         = csr_wdata;
            vpidff_pkg::RegStepTime:  cfg_in.step_time      = csr_wdata[15:0];
            vpidff_pkg::RegStepRate:  cfg_in.step_rate      = csr_wdata[23:0];
            vpidff_pkg::RegVelScale:  cfg_in.velocity_scale = csr_wdata[17:0];
            vpidff_pkg::RegMaxOutput: cfg_in.max_output     = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.step_time      <= vpidff_pkg::ResetStepTime;
         cfg_ff.step_rate      <= vpidff_pkg::ResetStepRate;
         cfg_ff.velocity_scale <= vpidff_pkg::ResetVelScale;
         cfg_ff.max_output     <= vpidff_pkg::ResetMaxOutput;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vpidff_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   vpidff_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_cmd     (req_tdata[15:0]),
      .req_meas    (req_tdata[33:16]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_volts   (rsp_tdata),
      .rsp_clamped (rsp_tuser),
      .status      (status)
   );

   assign req_tready = (ctrl.op == vpidff_pkg::DP_TAKE);

   assign lim_w   = {2'b0, cfg_ff.max_output};
   assign volts_w = {rsp_tdata[15], rsp_tdata};

   // Once an item is taken the program must leave its first step.
   a_take_once: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice without running the program");

   // A new result appears only from the output step of the program.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl.op == vpidff_pkg::DP_OUT))
      else $error("result raised outside the output step");

   // The voltage stays within the limit, and sits on it when flagged.
   a_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (volts_w <= lim_w && volts_w >= -lim_w))
      else $error("drive voltage beyond the limit");

   a_clamp_on_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (volts_w == lim_w || volts_w == -lim_w))
      else $error("clamp flag set away from the limit");

endmodule

// File: sim/tb_velocity_pid_with_feedforward_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the velocity PID controller with voltage feedforward
// Drives control ticks through the request stream and checks every drive
// voltage and clamp flag against a cycle-free prediction of the loop, which
// keeps its own integral, previous error and register copies. Directed ticks
// cover the field extremes, the zero voltage limit and the quiet derivative
// clearing. Random phases follow, each under a fresh register setting, with
// random idle gaps on both streams.
// ----------------------------------------------------------------------------
module tb_velocity_pid_with_feedforward_core;

   localparam logic [vpidff_pkg::CsrAddrW-1:0] RegUnused = 3'd7;
   localparam longint      IntegMax   = (64'sd1 <<< 39) - 1;
   localparam longint      IntegMin   = -(64'sd1 <<< 39);
   localparam logic [127:0] TermCap   = 128'd1 << 50;
   localparam int          SettleCycles = 32;
   localparam int          CycleLimit   = 1000000;
   localparam int          RandomPhases = 12;
   localparam int          PhaseTicks   = 125;

   typedef struct packed {
      logic [15:0] volts;
      logic        clamped;
   } volts_item_type;

   // Prediction of the loop and the store of drive voltages still to arrive.
   class drive_volts_tracker_type;
      logic [31:0] gain_p, gain_i, gain_d;
      logic [15:0] step_time;
      logic [23:0] step_rate;
      logic [17:0] vel_scale;
      logic [14:0] max_out;
      longint      integ;
      longint      prev_err;
      volts_item_type pending[$];
      int          mismatches;

      function new();
         gain_p     = '0;
         gain_i     = '0;
         gain_d     = '0;
         step_time  = vpidff_pkg::ResetStepTime;
         step_rate  = vpidff_pkg::ResetStepRate;
         vel_scale  = vpidff_pkg::ResetVelScale;
         max_out    = vpidff_pkg::ResetMaxOutput;
         integ      = 0;
         prev_err   = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [vpidff_pkg::CsrAddrW-1:0] idx, logic [31:0] value);
         case (idx)
            vpidff_pkg::RegGainP:     gain_p    = value;
            vpidff_pkg::RegGainI:     gain_i    = value;
            vpidff_pkg::RegGainD:     gain_d    = value;
            vpidff_pkg::RegStepTime:  step_time = value[15:0];
            vpidff_pkg::RegStepRate:  step_rate = value[23:0];
            vpidff_pkg::RegVelScale:  vel_scale = value[17:0];
            vpidff_pkg::RegMaxOutput: max_out   = value[14:0];
            default: ;
         endcase
      endfunction

      // Magnitude times gain, shifted down, so the result truncates toward zero,
      // then capped at 2^50.
      static function longint gain_term(longint v, logic [31:0] g, int sh);
         logic [127:0] mag;
         logic [127:0] prod;
         longint       part;
         mag = '0;
         mag[63:0] = (v < 0) ? -v : v;
         prod = (mag * {96'd0, g}) >> sh;
         if (prod > TermCap) prod = TermCap;
         part = prod[63:0];
         return (v < 0) ? -part : part;
      endfunction

      function void take_tick(logic signed [15:0] cmd, logic signed [17:0] meas);
         longint    c, m, vs, st, sr, mo;
         longint    target, err, deriv, sum, volts;
         logic      hit;
         volts_item_type e;
         c  = cmd;
         m  = meas;
         vs = vel_scale;
         st = step_time;
         sr = step_rate;
         mo = max_out;
         target = (c * vs) >>> 15;
         err = target - m;
         integ = integ + err * st;
         if (integ > IntegMax) integ = IntegMax;
         if (integ < IntegMin) integ = IntegMin;
         deriv = (err - prev_err) * sr;
         prev_err = err;
         // A steady large error means the wheel is stuck or saturated: drop the
         // derivative and flush the integral.
         if (deriv < vpidff_pkg::QuietDeriv && deriv > -vpidff_pkg::QuietDeriv &&
             err > vpidff_pkg::LargeError) begin
            deriv = 0;
            integ = 0;
         end
         sum = gain_term(err, gain_p, vpidff_pkg::ShiftP)
             + gain_term(integ, gain_i, vpidff_pkg::ShiftI)
             + gain_term(deriv, gain_d, vpidff_pkg::ShiftD) + ((mo * c) >>> 15);
         volts = sum;
         hit = 1'b0;
         if (sum >= mo) begin
            volts = mo;
            hit = 1'b1;
         end else if (sum <= -mo) begin
            volts = -mo;
            hit = 1'b1;
         end
         e.volts   = volts[15:0];
         e.clamped = hit;
         pending.push_back(e);
      endfunction

      function void check_result(logic [15:0] volts, logic clamped);
         volts_item_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: volts %0d clamped %0b", $signed(volts), clamped);
            return;
         end
         e = pending.pop_front();
         if (e.volts !== volts || e.clamped !== clamped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected volts %0d clamped %0b, got volts %0d clamped %0b",
                        $signed(e.volts), e.clamped, $signed(volts), clamped);
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata  = '0;  // drive_command, measured_velocity
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;        // drive_volts
   logic                rsp_tuser;        // clamped
   logic                csr_we     = 1'b0;
   logic [vpidff_pkg::CsrAddrW-1:0] csr_addr  = '0;
   logic [vpidff_pkg::CsrDataW-1:0] csr_wdata = '0;

   drive_volts_tracker_type tracker = new();
   int req_calm = 0;
   int rsp_calm = 0;
   int cycles   = 0;

   velocity_pid_with_feedforward_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly random gaps, with the odd stretch of back-to-back items.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   task automatic write_csr(input logic [vpidff_pkg::CsrAddrW-1:0] idx,
                            input logic [31:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(posedge clock);
      tracker.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic program_loop(input logic [31:0] gp, gi, gd, st, sr, vs, mo);
      write_csr(vpidff_pkg::RegGainP, gp);
      write_csr(vpidff_pkg::RegGainI, gi);
      write_csr(vpidff_pkg::RegGainD, gd);
      write_csr(vpidff_pkg::RegStepTime, st);
      write_csr(vpidff_pkg::RegStepRate, sr);
      write_csr(vpidff_pkg::RegVelScale, vs);
      write_csr(vpidff_pkg::RegMaxOutput, mo);
      write_csr(RegUnused, $urandom());
      csr_we = 1'b0;
   endtask

   task automatic send_tick(input logic signed [15:0] cmd, input logic signed [17:0] meas);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {6'd0, meas, cmd};
      req_tvalid = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.take_tick(cmd, meas);
      @(negedge clock);
   endtask

   // Holds the sender until every result is in and the block has gone quiet.
   task automatic wait_for_results();
      req_tvalid = 1'b0;
      while (tracker.pending.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic random_phase(input int kind, input int count);
      logic [31:0]        r [7];
      logic signed [15:0] cmd;
      logic signed [17:0] meas;
      longint             aim;
      int                 n, pick, run, k, up;
      for (k = 0; k < 7; k++) begin
         case (kind)
            0: r[k] = $urandom();
            1: r[k] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: r[k] = 32'h0;
         endcase
      end
      if (kind > 1) begin
         // Settings of the kind a real drive would use.
         r[0] = $urandom_range(0, 32'h0004_0000);
         r[1] = $urandom_range(0, 32'h0010_0000);
         r[2] = $urandom_range(0, 32'h0000_4000);
         r[3] = $urandom_range(1, 4000);
         r[4] = $urandom_range(2560, 256000);
         r[5] = $urandom_range(1000, 40000);
         r[6] = $urandom_range(1024, 32767);
      end
      program_loop(r[0], r[1], r[2], r[3], r[4], r[5], r[6]);
      cmd  = '0;
      meas = '0;
      n    = 0;
      while (n < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // Sustained full-scale error to wind the integral into its limit.
            run = $urandom_range(8, 30);
            up  = $urandom_range(0, 1);
            for (k = 0; k < run && n < count; k++) begin
               cmd  = up ? 16'sh7FFF : 16'sh8000;
               meas = up ? (18'h20000 | k[0]) : (18'h1FFFF ^ k[0]);
               send_tick(cmd, meas);
               n++;
            end
         end else begin
            if (pick < 62) begin
               cmd = 16'($urandom());
               aim = (longint'(cmd) * longint'(tracker.vel_scale)) >>> 15;
               aim = aim + int'($urandom_range(0, 400)) - 200;
               if (aim > 131071) aim = 131071;
               if (aim < -131072) aim = -131072;
               meas = aim[17:0];
            end else if (pick < 82) begin
               cmd  = 16'($urandom());
               meas = 18'($urandom());
            end
            // Otherwise the previous tick is repeated, so the error holds still.
            send_tick(cmd, meas);
            n++;
         end
      end
   endtask

   initial begin
      int ph;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Power-on settings, field extremes.
      send_tick(16'sh7FFF, -18'sd131072);
      send_tick(16'sh8000, 18'sd131071);
      send_tick(16'sd0, 18'sd0);
      send_tick(-16'sd1, -18'sd1);

      // Every register at its top: the derivative gain term saturates.
      wait_for_results();
      program_loop(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,
                   32'hFF_FFFF, 32'h3_FFFF, 32'h7FFF);
      send_tick(16'sh7FFF, -18'sd131072);
      send_tick(16'sh8000, 18'sd131071);
      send_tick(16'sh7FFF, 18'sd131071);
      send_tick(16'sh8000, -18'sd131072);

      // Zero voltage limit: output pinned at zero with the flag set.
      wait_for_results();
      program_loop(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_tick(16'sd12345, -18'sd500);
      send_tick(16'sh8000, 18'sd131071);

      // Quiet derivative with errors either side of the large error threshold.
      wait_for_results();
      program_loop(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd1311,
                   32'd256, 32'd21777, 32'd12288);
      send_tick(16'sd0, -18'sd500);
      send_tick(16'sd0, -18'sd500);
      send_tick(16'sd0, -18'sd100);
      send_tick(16'sd0, -18'sd101);
      send_tick(16'sd0, -18'sd101);

      for (ph = 0; ph < RandomPhases; ph++) begin
         wait_for_results();
         random_phase(ph % 3, PhaseTicks);
      end

      wait_for_results();
      if (tracker.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         int gap;
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         tracker.check_result(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
design/vpidff_pkg.sv
design/vpidff_seq.sv
design/vpidff_dp.sv
design/velocity_pid_with_feedforward_core.sv
sim/tb_velocity_pid_with_feedforward_core.sv
